// ----- rtl/triangle_rasterizer_barycentric_macros.svh -----
// Assertion helpers for the triangle rasterizer.
// Both forms take the clock and the active-low reset from the module's scope.
`ifndef TRIANGLE_RASTERIZER_BARYCENTRIC_MACROS_SVH
`define TRIANGLE_RASTERIZER_BARYCENTRIC_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define TRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRB_ASSERT_NOW(label, ante, cons, msg)
`define TRB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/trirast_pkg.sv -----
package trirast_pkg;

    // Sequencer states.
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_PIXEL,
        ST_DIV,
        ST_BLEND,
        ST_OUT
    } state_t;

    // Item kinds carried on tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SHADE  = 2'd2;
    localparam logic [1:0] REG_FLAT   = 2'd3;

    // Vertex slots.
    localparam logic [1:0] VTX_0    = 2'd0;
    localparam logic [1:0] VTX_1    = 2'd1;
    localparam logic [1:0] VTX_LAST = 2'd2;

    // Field widths.
    localparam int VTX_W      = 14;
    localparam int PIX_OUT_W  = 12;
    localparam int COLOR_W    = 8;
    localparam int OFF_W      = 22;
    localparam int SIZE_W     = 12;
    localparam int DOT_W      = 32;
    localparam int WIDE_W     = 64;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_W      = 24;

    // Microstep counter and the final step of each phase.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] SETUP_LAST = 4'd8;
    localparam logic [STEP_W-1:0] PIXEL_LAST = 4'd10;
    localparam logic [STEP_W-1:0] BLEND_LAST = 4'd9;

    // Saturate a nonnegative blend sum to one color channel.
    function automatic logic [COLOR_W-1:0] sat8(input logic [WIDE_W-1:0] v);
        logic [COLOR_W-1:0] r;
        begin
            r = (v > 64'd255) ? 8'hFF : v[COLOR_W-1:0];
            return r;
        end
    endfunction

endpackage

// ----- rtl/triangle_rasterizer_barycentric.sv -----
// Load beat: stores one vertex; loading vertex 2 runs triangle setup on the shared multiplier.
// A step beat with a drawn Gouraud pixel runs the pixel phase, the divider (s weight, then t
// weight) and the blend; flat or unwritten pixels of a nondegenerate triangle run only the
// pixel phase, and a step with no active scan or on a degenerate triangle goes straight to
// the output register. One beat is in flight at a time.
// rst_n clears the sequencer, the setup results, the scan and the registers to their defaults.
`include "triangle_rasterizer_barycentric_macros.svh"

module triangle_rasterizer_barycentric #(
    parameter int COORD_FRAC_BITS  = 2,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vertex_index, vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue
    input  logic [trirast_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_x, pixel_y, write_enable, frame_offset, red, green, blue
    output logic [trirast_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [trirast_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int QW   = WEIGHT_FRAC_BITS + 1;
    localparam int DCW  = $clog2(WEIGHT_FRAC_BITS + 1);
    localparam int SHW  = trirast_pkg::VTX_W + COORD_FRAC_BITS + 1;
    localparam int WW   = trirast_pkg::VTX_W + 2;
    localparam int VW   = trirast_pkg::VTX_W;
    localparam int CW   = trirast_pkg::COLOR_W;
    localparam int OW   = trirast_pkg::OFF_W;
    localparam int SW   = trirast_pkg::SIZE_W;
    localparam int DW   = trirast_pkg::DOT_W;
    localparam int XW   = trirast_pkg::WIDE_W;
    localparam int STW  = trirast_pkg::STEP_W;
    localparam logic [DCW-1:0] DIV_LAST = DCW'(WEIGHT_FRAC_BITS);
    localparam logic [QW-1:0]  ONE_W    = QW'(1) << WEIGHT_FRAC_BITS;

    // Truncate a fixed-point coordinate toward zero to whole pixels.
    function automatic logic signed [VW-1:0] to_pix(input logic signed [VW-1:0] v);
        logic signed [VW:0] mag;
        logic signed [VW:0] sh;
        begin
            mag = v[VW-1] ? -(VW+1)'(v) : (VW+1)'(v);
            sh  = mag >>> COORD_FRAC_BITS;
            return v[VW-1] ? VW'(-sh) : VW'(sh);
        end
    endfunction

    // ------------------------------------------------------------------
    // Beat fields
    // ------------------------------------------------------------------
    logic                   in_cmd;
    logic [1:0]             in_idx;
    logic signed [VW-1:0]   in_x;
    logic signed [VW-1:0]   in_y;
    logic [CW-1:0]          in_r;
    logic [CW-1:0]          in_g;
    logic [CW-1:0]          in_b;
    logic                   in_acc;

    assign in_cmd = s_axis_tuser;
    assign in_idx = s_axis_tdata[1:0];
    assign in_x   = s_axis_tdata[15:2];
    assign in_y   = s_axis_tdata[29:16];
    assign in_r   = s_axis_tdata[37:30];
    assign in_g   = s_axis_tdata[45:38];
    assign in_b   = s_axis_tdata[53:46];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    trirast_pkg::state_t state_reg, state_next;
    logic [STW-1:0]         step_reg, step_next;

    logic [SW-1:0]          cfg_w_reg;
    logic [SW-1:0]          cfg_h_reg;
    logic                   shade_reg;
    logic [23:0]            flat_reg;

    logic signed [VW-1:0]   v_x_reg [3];
    logic signed [VW-1:0]   v_y_reg [3];
    logic [CW-1:0]          v_r_reg [3];
    logic [CW-1:0]          v_g_reg [3];
    logic [CW-1:0]          v_b_reg [3];

    logic signed [DW-1:0]   uu_reg, uu_next;
    logic signed [DW-1:0]   uv_reg, uv_next;
    logic signed [DW-1:0]   vv_reg, vv_next;
    logic signed [XW-1:0]   den_reg, den_next;

    logic signed [VW-1:0]   bmin_x_reg, bmin_x_next;
    logic signed [VW-1:0]   bmax_x_reg, bmax_x_next;
    logic signed [VW-1:0]   bmin_y_reg, bmin_y_next;
    logic signed [VW-1:0]   bmax_y_reg, bmax_y_next;
    logic signed [VW-1:0]   cur_x_reg, cur_x_next;
    logic signed [VW-1:0]   cur_y_reg, cur_y_next;
    logic                   scan_active_reg, scan_active_next;

    logic signed [XW-1:0]   prod_reg;
    logic signed [XW-1:0]   acc_reg, acc_next;
    logic signed [DW-1:0]   uw_reg, uw_next;
    logic signed [DW-1:0]   vw_reg, vw_next;
    logic signed [XW-1:0]   ns_reg, ns_next;
    logic signed [XW-1:0]   nt_reg, nt_next;

    logic [XW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]          q_reg, q_next;
    logic [DCW-1:0]         div_cnt_reg, div_cnt_next;
    logic                   div_sel_reg, div_sel_next;
    logic [QW-1:0]          ws_reg, ws_next;
    logic [QW-1:0]          wt_reg, wt_next;

    logic signed [VW-1:0]   res_x_reg, res_x_next;
    logic signed [VW-1:0]   res_y_reg, res_y_next;
    logic                   res_we_reg, res_we_next;
    logic [OW-1:0]          res_off_reg, res_off_next;
    logic [CW-1:0]          res_r_reg, res_r_next;
    logic [CW-1:0]          res_g_reg, res_g_next;
    logic [CW-1:0]          res_b_reg, res_b_next;
    logic                   res_last_reg, res_last_next;

    logic                   m_valid_reg, m_valid_next;
    logic [trirast_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Edge vectors, pixel offset from vertex 0 and the bounding box
    // ------------------------------------------------------------------
    logic signed [VW:0]     ux, uy, vx, vy;
    logic signed [SHW-1:0]  px_sh, py_sh;
    logic signed [WW-1:0]   wx, wy;
    logic signed [VW-1:0]   mn_x, mx_x, mn_y, mx_y;
    logic signed [VW-1:0]   box_min_x, box_max_x, box_min_y, box_max_y;

    assign ux = (VW+1)'(v_x_reg[1]) - (VW+1)'(v_x_reg[0]);
    assign uy = (VW+1)'(v_y_reg[1]) - (VW+1)'(v_y_reg[0]);
    assign vx = (VW+1)'(v_x_reg[2]) - (VW+1)'(v_x_reg[0]);
    assign vy = (VW+1)'(v_y_reg[2]) - (VW+1)'(v_y_reg[0]);

    assign px_sh = SHW'(res_x_reg) <<< COORD_FRAC_BITS;
    assign py_sh = SHW'(res_y_reg) <<< COORD_FRAC_BITS;
    assign wx    = WW'(px_sh - SHW'(v_x_reg[0]));
    assign wy    = WW'(py_sh - SHW'(v_y_reg[0]));

    always_comb
    begin
        mn_x = v_x_reg[0];
        mx_x = v_x_reg[0];
        mn_y = v_y_reg[0];
        mx_y = v_y_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (v_x_reg[i] < mn_x) mn_x = v_x_reg[i];
            if (v_x_reg[i] > mx_x) mx_x = v_x_reg[i];
            if (v_y_reg[i] < mn_y) mn_y = v_y_reg[i];
            if (v_y_reg[i] > mx_y) mx_y = v_y_reg[i];
        end
    end

    assign box_min_x = to_pix(mn_x);
    assign box_max_x = to_pix(mx_x);
    assign box_min_y = to_pix(mn_y);
    assign box_max_y = to_pix(mx_y);

    // ------------------------------------------------------------------
    // Shared multiplier, accumulator and divider step
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [XW-1:0]   prod_full;
    logic signed [XW-1:0]   sum_ap, diff_ap;
    logic [XW-1:0]          div_t;
    logic                   div_ge;
    logic [QW-1:0]          q_step;

    assign prod_full = mul_a * mul_b;
    assign sum_ap    = acc_reg + prod_reg;
    assign diff_ap   = acc_reg - prod_reg;

    assign div_t  = (div_cnt_reg == '0) ? rem_reg : {rem_reg[XW-2:0], 1'b0};
    assign div_ge = div_t >= XW'(den_reg);
    assign q_step = {q_reg[QW-2:0], div_ge};

    // ------------------------------------------------------------------
    // Coverage, clip, frame offset and the vertex-0 weight
    // ------------------------------------------------------------------
    logic [XW:0]            st_sum;
    logic                   covered;
    logic [VW:0]            ax, ay;
    logic                   in_clip;
    logic                   draw;
    logic [OW-1:0]          off_fin;
    logic [QW:0]            wsum;
    logic [QW-1:0]          w0;
    logic signed [VW:0]     cy_inc, cx_inc;
    logic                   den_pos;

    assign st_sum  = {1'b0, ns_reg} + {1'b0, nt_reg};
    assign covered = !ns_reg[XW-1] && !nt_reg[XW-1] && (st_sum <= {1'b0, den_reg});
    assign ax      = res_x_reg[VW-1] ? -(VW+1)'(res_x_reg) : (VW+1)'(res_x_reg);
    assign ay      = res_y_reg[VW-1] ? -(VW+1)'(res_y_reg) : (VW+1)'(res_y_reg);
    assign in_clip = (ax < (VW+1)'(cfg_w_reg >> 1)) && (ay < (VW+1)'(cfg_h_reg >> 1));
    assign draw    = covered && in_clip;
    assign off_fin = res_off_reg - prod_reg[OW-1:0];
    assign wsum    = {1'b0, ws_reg} + {1'b0, wt_reg};
    assign w0      = (wsum >= {1'b0, ONE_W}) ? '0 : QW'({1'b0, ONE_W} - wsum);
    assign cy_inc  = (VW+1)'(cur_y_reg) + (VW+1)'(1);
    assign cx_inc  = (VW+1)'(cur_x_reg) + (VW+1)'(1);
    assign den_pos = den_reg > XW'(0);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic out_load;

    assign s_axis_tready = (state_reg == trirast_pkg::ST_IDLE);
    assign out_load      = (state_reg == trirast_pkg::ST_OUT) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trirast_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_cmd == trirast_pkg::CMD_STEP)
                        state_next = (scan_active_reg && den_pos) ? trirast_pkg::ST_PIXEL
                                                                  : trirast_pkg::ST_OUT;
                    else if (in_idx == trirast_pkg::VTX_LAST)
                        state_next = trirast_pkg::ST_SETUP;
                end
            end
            trirast_pkg::ST_SETUP:
            begin
                if (step_reg == trirast_pkg::SETUP_LAST)
                    state_next = trirast_pkg::ST_IDLE;
            end
            trirast_pkg::ST_PIXEL:
            begin
                if (step_reg == trirast_pkg::PIXEL_LAST)
                    state_next = (draw && !shade_reg) ? trirast_pkg::ST_DIV
                                                      : trirast_pkg::ST_OUT;
            end
            trirast_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST && div_sel_reg)
                    state_next = trirast_pkg::ST_BLEND;
            end
            trirast_pkg::ST_BLEND:
            begin
                if (step_reg == trirast_pkg::BLEND_LAST)
                    state_next = trirast_pkg::ST_OUT;
            end
            trirast_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = trirast_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = trirast_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control per state and microstep
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next        = (state_next != state_reg) ? '0 : step_reg + STW'(1);
        mul_a            = '0;
        mul_b            = '0;
        acc_next         = acc_reg;
        uu_next          = uu_reg;
        uv_next          = uv_reg;
        vv_next          = vv_reg;
        den_next         = den_reg;
        bmin_x_next      = bmin_x_reg;
        bmax_x_next      = bmax_x_reg;
        bmin_y_next      = bmin_y_reg;
        bmax_y_next      = bmax_y_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        scan_active_next = scan_active_reg;
        uw_next          = uw_reg;
        vw_next          = vw_reg;
        ns_next          = ns_reg;
        nt_next          = nt_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        div_cnt_next     = div_cnt_reg;
        div_sel_next     = div_sel_reg;
        ws_next          = ws_reg;
        wt_next          = wt_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_we_next      = res_we_reg;
        res_off_next     = res_off_reg;
        res_r_next       = res_r_reg;
        res_g_next       = res_g_reg;
        res_b_next       = res_b_reg;
        res_last_next    = res_last_reg;

        case (state_reg)
            // Take a beat: store a vertex, or latch the scan position and advance it.
            trirast_pkg::ST_IDLE:
            begin
                if (in_acc && in_cmd == trirast_pkg::CMD_STEP)
                begin
                    res_we_next  = 1'b0;
                    res_off_next = '0;
                    res_r_next   = '0;
                    res_g_next   = '0;
                    res_b_next   = '0;
                    if (!scan_active_reg)
                    begin
                        res_x_next    = '0;
                        res_y_next    = '0;
                        res_last_next = 1'b1;
                    end
                    else
                    begin
                        res_x_next    = cur_x_reg;
                        res_y_next    = cur_y_reg;
                        res_last_next = 1'b0;
                        if (cy_inc >= (VW+1)'(bmax_y_reg))
                        begin
                            cur_y_next = bmin_y_reg;
                            cur_x_next = VW'(cx_inc);
                            if (cx_inc >= (VW+1)'(bmax_x_reg))
                            begin
                                res_last_next    = 1'b1;
                                scan_active_next = 1'b0;
                            end
                        end
                        else
                        begin
                            cur_y_next = VW'(cy_inc);
                        end
                    end
                end
                else if (in_acc && (in_idx == trirast_pkg::VTX_0 ||
                                    in_idx == trirast_pkg::VTX_1))
                begin
                    scan_active_next = 1'b0;
                end
            end

            // Triangle setup: dot products, denominator and bounding box.
            trirast_pkg::ST_SETUP:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a            = DW'(ux);
                        mul_b            = DW'(ux);
                        bmin_x_next      = box_min_x;
                        bmax_x_next      = box_max_x;
                        bmin_y_next      = box_min_y;
                        bmax_y_next      = box_max_y;
                        cur_x_next       = box_min_x;
                        cur_y_next       = box_min_y;
                        scan_active_next = (box_min_x < box_max_x) && (box_min_y < box_max_y);
                    end
                    4'd1:
                    begin
                        mul_a    = DW'(uy);
                        mul_b    = DW'(uy);
                        acc_next = prod_reg;
                    end
                    4'd2:
                    begin
                        mul_a   = DW'(ux);
                        mul_b   = DW'(vx);
                        uu_next = DW'(sum_ap);
                    end
                    4'd3:
                    begin
                        mul_a    = DW'(uy);
                        mul_b    = DW'(vy);
                        acc_next = prod_reg;
                    end
                    4'd4:
                    begin
                        mul_a   = DW'(vx);
                        mul_b   = DW'(vx);
                        uv_next = DW'(sum_ap);
                    end
                    4'd5:
                    begin
                        mul_a    = DW'(vy);
                        mul_b    = DW'(vy);
                        acc_next = prod_reg;
                    end
                    4'd6:
                    begin
                        vv_next = DW'(sum_ap);
                        mul_a   = uv_reg;
                        mul_b   = uv_reg;
                    end
                    4'd7:
                    begin
                        acc_next = prod_reg;
                        mul_a    = uu_reg;
                        mul_b    = vv_reg;
                    end
                    4'd8:
                    begin
                        den_next = prod_reg - acc_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Per-pixel numerators, coverage test and frame offset.
            trirast_pkg::ST_PIXEL:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = DW'(ux);
                        mul_b = DW'(wx);
                    end
                    4'd1:
                    begin
                        mul_a    = DW'(uy);
                        mul_b    = DW'(wy);
                        acc_next = prod_reg;
                    end
                    4'd2:
                    begin
                        mul_a   = DW'(vx);
                        mul_b   = DW'(wx);
                        uw_next = DW'(sum_ap);
                    end
                    4'd3:
                    begin
                        mul_a    = DW'(vy);
                        mul_b    = DW'(wy);
                        acc_next = prod_reg;
                    end
                    4'd4:
                    begin
                        vw_next = DW'(sum_ap);
                        mul_a   = vv_reg;
                        mul_b   = uw_reg;
                    end
                    4'd5:
                    begin
                        acc_next = prod_reg;
                        mul_a    = uv_reg;
                        mul_b    = vw_reg;
                    end
                    4'd6:
                    begin
                        ns_next = diff_ap;
                        mul_a   = uu_reg;
                        mul_b   = vw_reg;
                    end
                    4'd7:
                    begin
                        acc_next = prod_reg;
                        mul_a    = uv_reg;
                        mul_b    = uw_reg;
                    end
                    4'd8:
                    begin
                        nt_next = diff_ap;
                        mul_a   = DW'(cfg_w_reg);
                        mul_b   = DW'(cfg_h_reg);
                    end
                    4'd9:
                    begin
                        res_off_next = prod_reg[OW:1] + OW'(cfg_w_reg >> 1) + OW'(res_x_reg);
                        mul_a        = DW'(cfg_w_reg);
                        mul_b        = DW'(res_y_reg);
                    end
                    4'd10:
                    begin
                        res_we_next  = draw;
                        res_off_next = draw ? off_fin : '0;
                        if (draw && shade_reg)
                        begin
                            res_r_next = flat_reg[23:16];
                            res_g_next = flat_reg[15:8];
                            res_b_next = flat_reg[7:0];
                        end
                        rem_next     = XW'(ns_reg);
                        q_next       = '0;
                        div_cnt_next = '0;
                        div_sel_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Restoring division, one quotient bit a cycle, s weight then t weight.
            trirast_pkg::ST_DIV:
            begin
                rem_next     = div_ge ? div_t - XW'(den_reg) : div_t;
                q_next       = q_step;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    div_cnt_next = '0;
                    q_next       = '0;
                    if (!div_sel_reg)
                    begin
                        ws_next      = q_step;
                        rem_next     = XW'(nt_reg);
                        div_sel_next = 1'b1;
                    end
                    else
                    begin
                        wt_next = q_step;
                    end
                end
            end

            // Gouraud blend, three products per channel.
            trirast_pkg::ST_BLEND:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = DW'(v_r_reg[0]);
                        mul_b = DW'(w0);
                    end
                    4'd1:
                    begin
                        mul_a    = DW'(v_r_reg[1]);
                        mul_b    = DW'(ws_reg);
                        acc_next = prod_reg;
                    end
                    4'd2:
                    begin
                        mul_a    = DW'(v_r_reg[2]);
                        mul_b    = DW'(wt_reg);
                        acc_next = sum_ap;
                    end
                    4'd3:
                    begin
                        mul_a      = DW'(v_g_reg[0]);
                        mul_b      = DW'(w0);
                        res_r_next = trirast_pkg::sat8(XW'(sum_ap >>> WEIGHT_FRAC_BITS));
                    end
                    4'd4:
                    begin
                        mul_a    = DW'(v_g_reg[1]);
                        mul_b    = DW'(ws_reg);
                        acc_next = prod_reg;
                    end
                    4'd5:
                    begin
                        mul_a    = DW'(v_g_reg[2]);
                        mul_b    = DW'(wt_reg);
                        acc_next = sum_ap;
                    end
                    4'd6:
                    begin
                        mul_a      = DW'(v_b_reg[0]);
                        mul_b      = DW'(w0);
                        res_g_next = trirast_pkg::sat8(XW'(sum_ap >>> WEIGHT_FRAC_BITS));
                    end
                    4'd7:
                    begin
                        mul_a    = DW'(v_b_reg[1]);
                        mul_b    = DW'(ws_reg);
                        acc_next = prod_reg;
                    end
                    4'd8:
                    begin
                        mul_a    = DW'(v_b_reg[2]);
                        mul_b    = DW'(wt_reg);
                        acc_next = sum_ap;
                    end
                    4'd9:
                    begin
                        res_b_next = trirast_pkg::sat8(XW'(sum_ap >>> WEIGHT_FRAC_BITS));
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, res_b_reg, res_g_reg, res_r_reg, res_off_reg, res_we_reg,
                            res_y_reg[trirast_pkg::PIX_OUT_W-1:0],
                            res_x_reg[trirast_pkg::PIX_OUT_W-1:0]};
            m_last_next  = res_last_reg;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control and setup state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= trirast_pkg::ST_IDLE;
            step_reg        <= '0;
            cfg_w_reg       <= 12'd640;
            cfg_h_reg       <= 12'd480;
            shade_reg       <= 1'b0;
            flat_reg        <= '0;
            uu_reg          <= '0;
            uv_reg          <= '0;
            vv_reg          <= '0;
            den_reg         <= '0;
            bmin_x_reg      <= '0;
            bmax_x_reg      <= '0;
            bmin_y_reg      <= '0;
            bmax_y_reg      <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            scan_active_reg <= 1'b0;
            div_cnt_reg     <= '0;
            div_sel_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            uu_reg          <= uu_next;
            uv_reg          <= uv_next;
            vv_reg          <= vv_next;
            den_reg         <= den_next;
            bmin_x_reg      <= bmin_x_next;
            bmax_x_reg      <= bmax_x_next;
            bmin_y_reg      <= bmin_y_next;
            bmax_y_reg      <= bmax_y_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            scan_active_reg <= scan_active_next;
            div_cnt_reg     <= div_cnt_next;
            div_sel_reg     <= div_sel_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    trirast_pkg::REG_WIDTH:  cfg_w_reg <= cfg_wdata[SW-1:0];
                    trirast_pkg::REG_HEIGHT: cfg_h_reg <= cfg_wdata[SW-1:0];
                    trirast_pkg::REG_SHADE:  shade_reg <= cfg_wdata[0];
                    trirast_pkg::REG_FLAT:   flat_reg  <= cfg_wdata[23:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_full;
        acc_reg      <= acc_next;
        uw_reg       <= uw_next;
        vw_reg       <= vw_next;
        ns_reg       <= ns_next;
        nt_reg       <= nt_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        ws_reg       <= ws_next;
        wt_reg       <= wt_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_we_reg   <= res_we_next;
        res_off_reg  <= res_off_next;
        res_r_reg    <= res_r_next;
        res_g_reg    <= res_g_next;
        res_b_reg    <= res_b_next;
        res_last_reg <= res_last_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        if (in_acc && in_cmd == trirast_pkg::CMD_LOAD && in_idx <= trirast_pkg::VTX_LAST)
        begin
            v_x_reg[in_idx] <= in_x;
            v_y_reg[in_idx] <= in_y;
            v_r_reg[in_idx] <= in_r;
            v_g_reg[in_idx] <= in_g;
            v_b_reg[in_idx] <= in_b;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TRB_ASSERT_NOW(a_div_nonzero_den, state_reg == trirast_pkg::ST_DIV, den_reg > XW'(0),
        "division started with a non-positive denominator")
    `TRB_ASSERT_NOW(a_div_count_range, state_reg == trirast_pkg::ST_DIV, div_cnt_reg <= DIV_LAST,
        "divider step count out of range")
    `TRB_ASSERT_NEXT(a_idle_step_last,
        in_acc && in_cmd == trirast_pkg::CMD_STEP && !scan_active_reg,
        state_reg == trirast_pkg::ST_OUT && res_last_reg,
        "step beat without an active scan did not produce a last beat")

endmodule

// ----- test/tb_triangle_rasterizer_barycentric.sv -----
module tb_triangle_rasterizer_barycentric;

    // One input beat: command, vertex slot, position and color.
    typedef struct {
        logic              cmd;
        logic [1:0]        idx;
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
    } raster_cmd_t;

    // One output beat, as expected by the pixel predictor.
    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        logic        we;
        logic [21:0] off;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        last;
    } pixel_t;

    localparam int WFB = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // vertex_index, vertex_x, vertex_y, red, green, blue
    logic [trirast_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // pixel_x, pixel_y, write_enable, offset, r, g, b
    logic [trirast_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [trirast_pkg::CFG_W-1:0]      cfg_wdata;

    triangle_rasterizer_barycentric i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock with a 10 unit period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    raster_cmd_t pending_cmds[$];
    raster_cmd_t cur_cmd;
    pixel_t      expected_pixels[$];
    int          errors;
    int          idle_mode;
    int          steps_sent;
    int          pixels_drawn;
    int          hold_left;
    logic        hold_start;

    // Predictor state: registers, vertices, setup and scan position.
    int unsigned scr_w, scr_h, flat_mode, flat_rgb;
    longint      vtx_x[3], vtx_y[3];
    int          vtx_r[3], vtx_g[3], vtx_b[3];
    longint      d_uu, d_uv, d_vv, denom;
    longint      box_x0, box_x1, box_y0, box_y1, scan_x, scan_y;
    bit          scanning;

    // Quarter-pixel position to pixel, truncating toward zero.
    function automatic longint to_pix(longint v);
        return (v < 0) ? -((-v) >>> 2) : (v >>> 2);
    endfunction

    // Restoring division: floor(num * 2^WFB / den) with num <= den.
    function automatic longint unsigned weight_of(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = 0;
        rem = num;
        if (rem >= den)
        begin
            q = 1;
            rem -= den;
        end
        for (int i = 0; i < WFB; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    // Weighted sum of three channel values, saturated to 8 bits.
    function automatic logic [7:0] shade(int c0, int c1, int c2, longint unsigned w0,
                                         longint unsigned ws, longint unsigned wt);
        longint unsigned acc;
        acc = (c0 * w0 + c1 * ws + c2 * wt) >> WFB;
        return (acc > 255) ? 8'hFF : acc[7:0];
    endfunction

    // Apply one accepted beat to the predictor; returns 1 when a pixel beat follows.
    function automatic bit raster_predict(raster_cmd_t c, output pixel_t p);
        longint ux, uy, vx, vy, wx, wy, uw, vw, ns, nt, o, px, py;
        longint unsigned ws, wt, w0;
        int k;
        p = '{default: '0};
        if (c.cmd == trirast_pkg::CMD_LOAD)
        begin
            if (c.idx > trirast_pkg::VTX_LAST)
                return 0;
            k = c.idx;
            vtx_x[k] = c.x;
            vtx_y[k] = c.y;
            vtx_r[k] = c.r;
            vtx_g[k] = c.g;
            vtx_b[k] = c.b;
            if (c.idx != trirast_pkg::VTX_LAST)
            begin
                scanning = 0;
                return 0;
            end
            ux = vtx_x[1] - vtx_x[0];
            uy = vtx_y[1] - vtx_y[0];
            vx = vtx_x[2] - vtx_x[0];
            vy = vtx_y[2] - vtx_y[0];
            d_uu = ux * ux + uy * uy;
            d_uv = ux * vx + uy * vy;
            d_vv = vx * vx + vy * vy;
            denom = d_uu * d_vv - d_uv * d_uv;
            box_x0 = vtx_x[0];
            box_x1 = vtx_x[0];
            box_y0 = vtx_y[0];
            box_y1 = vtx_y[0];
            for (int i = 1; i < 3; i++)
            begin
                if (vtx_x[i] < box_x0) box_x0 = vtx_x[i];
                if (vtx_x[i] > box_x1) box_x1 = vtx_x[i];
                if (vtx_y[i] < box_y0) box_y0 = vtx_y[i];
                if (vtx_y[i] > box_y1) box_y1 = vtx_y[i];
            end
            box_x0 = to_pix(box_x0);
            box_x1 = to_pix(box_x1);
            box_y0 = to_pix(box_y0);
            box_y1 = to_pix(box_y1);
            scan_x = box_x0;
            scan_y = box_y0;
            scanning = (box_x0 < box_x1) && (box_y0 < box_y1);
            return 0;
        end

        if (!scanning)
        begin
            p.last = 1'b1;
            return 1;
        end
        px = scan_x;
        py = scan_y;
        if (denom > 0)
        begin
            ux = vtx_x[1] - vtx_x[0];
            uy = vtx_y[1] - vtx_y[0];
            vx = vtx_x[2] - vtx_x[0];
            vy = vtx_y[2] - vtx_y[0];
            wx = px * 4 - vtx_x[0];
            wy = py * 4 - vtx_y[0];
            uw = ux * wx + uy * wy;
            vw = vx * wx + vy * wy;
            ns = d_vv * uw - d_uv * vw;
            nt = d_uu * vw - d_uv * uw;
            if (ns >= 0 && nt >= 0 && ns + nt <= denom &&
                (px < 0 ? -px : px) < longint'(scr_w / 2) &&
                (py < 0 ? -py : py) < longint'(scr_h / 2))
            begin
                o = (longint'(scr_w) * scr_h) / 2 + scr_w / 2 + px - longint'(scr_w) * py;
                p.we = 1'b1;
                p.off = o[21:0];
                if (flat_mode != 0)
                begin
                    p.r = flat_rgb[23:16];
                    p.g = flat_rgb[15:8];
                    p.b = flat_rgb[7:0];
                end
                else
                begin
                    ws = weight_of(ns, denom);
                    wt = weight_of(nt, denom);
                    w0 = (ws + wt >= (64'd1 << WFB)) ? 0 : (64'd1 << WFB) - ws - wt;
                    p.r = shade(vtx_r[0], vtx_r[1], vtx_r[2], w0, ws, wt);
                    p.g = shade(vtx_g[0], vtx_g[1], vtx_g[2], w0, ws, wt);
                    p.b = shade(vtx_b[0], vtx_b[1], vtx_b[2], w0, ws, wt);
                end
            end
        end
        scan_y++;
        if (scan_y >= box_y1)
        begin
            scan_y = box_y0;
            scan_x++;
            if (scan_x >= box_x1)
            begin
                p.last = 1'b1;
                scanning = 0;
            end
        end
        p.px = px[11:0];
        p.py = py[11:0];
        return 1;
    endfunction

    // Print one mismatch and count it.
    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Driver: predicts each accepted beat and offers the next pending command.
    always @(posedge clk)
    begin
        pixel_t p;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (raster_predict(cur_cmd, p))
                begin
                    expected_pixels.push_back(p);
                    steps_sent++;
                    if (p.we)
                        pixels_drawn++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 &&
                    !(idle_mode == 0 && $urandom_range(99) < 34) &&
                    !(idle_mode == 1 && $urandom_range(99) < 68))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_axis_tdata <= {2'b00, cur_cmd.b, cur_cmd.g, cur_cmd.r,
                                     cur_cmd.y, cur_cmd.x, cur_cmd.idx};
                    s_axis_tuser <= cur_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: drives tready and checks each pixel beat against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t       p;
        longint       got[8];
        longint       want[8];
        string        names[8];
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected pixel beat", m_axis_tdata[23:0], 0);
                end
                else
                begin
                    p = expected_pixels.pop_front();
                    names = '{"pixel_x", "pixel_y", "write_enable", "frame_offset",
                              "red", "green", "blue", "last"};
                    got = '{m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[24],
                            m_axis_tdata[46:25], m_axis_tdata[54:47], m_axis_tdata[62:55],
                            m_axis_tdata[70:63], m_axis_tlast};
                    want = '{p.px, p.py, p.we, p.off, p.r, p.g, p.b, p.last};
                    for (int i = 0; i < 8; i++)
                        if (got[i] != want[i])
                            report_mismatch(names[i], got[i], want[i]);
                end
            end
            m_axis_tready <= (hold_left == 0) &&
                             !(idle_mode == 0 && $urandom_range(99) < 68) &&
                             !(idle_mode == 1 && $urandom_range(99) < 34);
        end
    end

    // Register write; the predictor takes the value at the same edge.
    task automatic cfg_write(logic [1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[trirast_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            trirast_pkg::REG_WIDTH:  scr_w = val & 12'hFFF;
            trirast_pkg::REG_HEIGHT: scr_h = val & 12'hFFF;
            trirast_pkg::REG_SHADE:  flat_mode = val & 1;
            default:                 flat_rgb = val & 24'hFFFFFF;
        endcase
    endtask

    task automatic add_cmd(logic cmd, logic [1:0] idx, int x, int y, int r, int g, int b);
        raster_cmd_t c;
        c.cmd = cmd;
        c.idx = idx;
        c.x = x;
        c.y = y;
        c.r = r;
        c.g = g;
        c.b = b;
        pending_cmds.push_back(c);
    endtask

    // A random triangle near a random center, then step beats for its box, at most 60.
    task automatic add_triangle(int center_span, int spread);
        int cx, cy, n, bw, bh;
        int xs[3], ys[3];
        cx = int'($urandom_range(2 * center_span)) - center_span;
        cy = int'($urandom_range(2 * center_span)) - center_span;
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = cx + int'($urandom_range(2 * spread)) - spread;
            ys[i] = cy + int'($urandom_range(2 * spread)) - spread;
            xs[i] = (xs[i] > 8191) ? 8191 : (xs[i] < -8192) ? -8192 : xs[i];
            ys[i] = (ys[i] > 8191) ? 8191 : (ys[i] < -8192) ? -8192 : ys[i];
        end
        // Degenerate triangle: the third vertex repeats the first.
        if ($urandom_range(9) == 0)
        begin
            xs[2] = xs[0];
            ys[2] = ys[0];
        end
        for (int i = 0; i < 3; i++)
        begin
            // Ignored load to slot 3 now and then.
            if ($urandom_range(15) == 0)
                add_cmd(trirast_pkg::CMD_LOAD, 2'd3, $urandom_range(16383),
                        $urandom_range(16383), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255));
            add_cmd(trirast_pkg::CMD_LOAD, i[1:0], xs[i], ys[i],
                    $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
        bw = to_pix(xs[0] > xs[1] ? (xs[0] > xs[2] ? xs[0] : xs[2]) : (xs[1] > xs[2] ? xs[1] : xs[2]))
             - to_pix(xs[0] < xs[1] ? (xs[0] < xs[2] ? xs[0] : xs[2]) : (xs[1] < xs[2] ? xs[1] : xs[2]));
        bh = to_pix(ys[0] > ys[1] ? (ys[0] > ys[2] ? ys[0] : ys[2]) : (ys[1] > ys[2] ? ys[1] : ys[2]))
             - to_pix(ys[0] < ys[1] ? (ys[0] < ys[2] ? ys[0] : ys[2]) : (ys[1] < ys[2] ? ys[1] : ys[2]));
        n = bw * bh + int'($urandom_range(2));
        if (n > 60)
            n = 60;
        for (int i = 0; i < n; i++)
        begin
            // Occasionally cancel the scan midway by reloading vertex 0.
            if (i == n / 2 && $urandom_range(9) == 0)
                add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_0, xs[0], ys[0], 0, 0, 0);
            add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        end
    endtask

    // Wait until nothing is in flight, then give the block time to settle.
    task automatic drain();
        while (pending_cmds.size() != 0 || expected_pixels.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Fill one phase with random triangles.
    task automatic run_phase(int center_span, int n_cmds);
        int target;
        target = pending_cmds.size() + n_cmds;
        while (pending_cmds.size() < target)
            add_triangle(center_span, ($urandom_range(7) == 0) ? 24 : 12);
    endtask

    // Stimulus and phase sequencing.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = trirast_pkg::REG_WIDTH;
        cfg_wdata = '0;
        hold_start = 1'b0;
        hold_left = 0;
        errors = 0;
        steps_sent = 0;
        pixels_drawn = 0;
        idle_mode = 0;
        scr_w = 640;
        scr_h = 480;
        flat_mode = 0;
        flat_rgb = 0;
        for (int i = 0; i < 3; i++)
        begin
            vtx_x[i] = 0;
            vtx_y[i] = 0;
            vtx_r[i] = 0;
            vtx_g[i] = 0;
            vtx_b[i] = 0;
        end
        d_uu = 0;
        d_uv = 0;
        d_vv = 0;
        denom = 0;
        box_x0 = 0;
        box_x1 = 0;
        box_y0 = 0;
        box_y1 = 0;
        scan_x = 0;
        scan_y = 0;
        scanning = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: steps with no scan, an ignored slot, extreme vertices,
        // a cancelled scan and a small fully scanned triangle.
        cfg_write(trirast_pkg::REG_WIDTH, 640);
        cfg_write(trirast_pkg::REG_HEIGHT, 480);
        cfg_write(trirast_pkg::REG_SHADE, 0);
        cfg_write(trirast_pkg::REG_FLAT, 24'h123456);
        add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        add_cmd(trirast_pkg::CMD_LOAD, 2'd3, 8191, -8192, 255, 255, 255);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_0, -8192, 8191, 0, 0, 0);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_1, 8191, -8192, 255, 255, 255);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_LAST, -8192, -8192, 255, 0, 255);
        repeat (3) add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_1, 16, 0, 0, 255, 0);
        add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_0, 0, 0, 255, 0, 0);
        add_cmd(trirast_pkg::CMD_LOAD, trirast_pkg::VTX_LAST, 0, 16, 0, 0, 255);
        repeat (17) add_cmd(trirast_pkg::CMD_STEP, trirast_pkg::VTX_0, 0, 0, 0, 0, 0);
        run_phase(2000, 450);
        drain();

        // Tiny screen, flat color, roles of the two sides swapped.
        idle_mode = 1;
        cfg_write(trirast_pkg::REG_WIDTH, 2);
        cfg_write(trirast_pkg::REG_HEIGHT, 2);
        cfg_write(trirast_pkg::REG_SHADE, 1);
        cfg_write(trirast_pkg::REG_FLAT, 24'hFFFFFF);
        run_phase(40, 500);
        drain();

        // A 2048 by 2048 screen, Gouraud, no idling.
        idle_mode = 2;
        cfg_write(trirast_pkg::REG_WIDTH, 2048);
        cfg_write(trirast_pkg::REG_HEIGHT, 2048);
        cfg_write(trirast_pkg::REG_SHADE, 0);
        cfg_write(trirast_pkg::REG_FLAT, 0);
        run_phase(8000, 500);
        drain();

        // Odd sizes outside the usual range, plus a long receiver hold-off.
        idle_mode = 0;
        cfg_write(trirast_pkg::REG_WIDTH, 4095);
        cfg_write(trirast_pkg::REG_HEIGHT, 1);
        cfg_write(trirast_pkg::REG_SHADE, 1);
        cfg_write(trirast_pkg::REG_FLAT, $urandom_range(24'hFFFFFF));
        run_phase(2000, 150);
        drain();
        cfg_write(trirast_pkg::REG_WIDTH, $urandom_range(4095));
        cfg_write(trirast_pkg::REG_HEIGHT, $urandom_range(4095));
        cfg_write(trirast_pkg::REG_SHADE, 0);
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        run_phase(2000, 350);
        drain();

        if (expected_pixels.size() != 0)
            report_mismatch("pixel beats never seen", expected_pixels.size(), 0);
        $display("Covered %0d step beats, %0d written pixels, over five register settings",
                 steps_sent, pixels_drawn);
        $display("with flat and Gouraud shading, clipping, degenerate and cancelled scans.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
